FILE: hw/rtl/gyro_angle_kalman_filter_macros.svh
// Assertion macros for the angle and gyro bias filter.
// Each takes a label, an antecedent and a consequent, sampled on i_clk,
// and is disabled while i_rst_n is low.
`ifndef GYRO_ANGLE_KALMAN_FILTER_MACROS_SVH
`define GYRO_ANGLE_KALMAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define GAKF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GAKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GAKF_ASSERT_SAME(lbl, ante, cons)
`define GAKF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/gakf_pkg.sv
package gakf_pkg;

    localparam int FRAC_BITS = 24;

    // Reset values of state and registers
    localparam logic signed [31:0] ANGLE_RESET   = 32'sd5898240;
    localparam logic [30:0]        ANGLE_NOISE_RESET = 31'd16777;
    localparam logic [30:0]        BIAS_NOISE_RESET  = 31'd50332;
    localparam logic [30:0]        MEAS_NOISE_RESET  = 31'd503316;

    // Configuration register indexes
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    // Opcodes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] gyro_rate;
        logic [24:0]        time_step;
        logic signed [31:0] measured_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
        logic               divide_fault;
    } t_out_word;

    // Magnitude of a 34-bit signed value
    function automatic logic [32:0] mag34(input logic signed [33:0] v);
        logic [33:0] t;
        t = v[33] ? 34'(-v) : 34'(v);
        return t[32:0];
    endfunction

    // Saturate a wide sum to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
        logic signed [31:0] r;
        if (v > 45'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -45'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/gyro_angle_kalman_filter.sv
// Two-state filter tracking an angle and a gyro bias (Q16.16 angles,
// unsigned Q1.24 time step, unsigned Q7.24 noise, Q8.24 covariance).
// Input channel: i_in_valid / o_in_stall carry one word; opcode 0 predicts
// with gyro_rate and time_step, opcode 1 updates with measured_angle.
// Output channel: o_out_valid / i_out_stall give one word per input word:
// angle and bias after the step, and divide_fault for a zero S.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0 angle
// noise, 1 bias noise, 2 measurement noise; write only while idle.
// Datapath: all products go through one 33x33 magnitude multiplier; each
// product is multiplied in S_MUL, then rounded and accumulated in S_ACC.
// A predict runs six products. An update runs two restoring divisions in
// turn on one shared divider, then six products. A faulted update goes
// from idle straight to S_OUT. The input stalls while a word is at work.
// A finished word waits in the output register while the receiver stalls;
// the next input word may be accepted meanwhile but finishes only once the
// output register is free.
// Reset: angle 90 degrees, bias and covariance zero, noise registers to
// their defaults, no output word pending.
`include "gyro_angle_kalman_filter_macros.svh"

module gyro_angle_kalman_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gakf_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gakf_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [30:0]          i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_DEND, S_MUL, S_ACC, S_OUT} t_state;
    typedef enum logic [2:0] {D_ANG, D_BIAS, D_AA, D_AB, D_BA, D_BB} t_dest;

    t_state r_state;

    // Filter state and registers
    logic signed [31:0] r_angle, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic [30:0]        r_apn, r_bpn, r_mn;

    // Per-word operands
    logic [24:0]        r_dt;
    logic signed [32:0] r_x;     // rate - bias, or the innovation
    logic signed [32:0] r_z;     // ba + ab
    logic signed [31:0] r_k0, r_k1;
    logic               r_fault;

    // Divider
    logic [55:0] r_dvd;
    logic [32:0] r_rem;
    logic [32:0] r_dmag;
    logic [31:0] r_q;
    logic        r_ovf;
    logic        r_dneg;
    logic        r_sneg;
    logic        r_dsel;
    logic [5:0]  r_cnt;

    // Multiplier and accumulator
    logic [3:0]         r_pi;
    logic [65:0]        r_prod;
    logic               r_neg;
    logic signed [44:0] r_acc;

    logic      r_out_valid;
    gakf_pkg::t_out_word r_out_word;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // Product table: operands, sign and destination per product
    logic signed [33:0] w_a, w_b;
    logic w_sub, w_first, w_last;
    t_dest w_dest;
    always_comb begin
        w_a = 34'(signed'({1'b0, r_dt}));
        w_b = 34'(r_x);
        w_sub = 1'b0;
        w_first = 1'b1;
        w_last = 1'b1;
        w_dest = D_ANG;
        case (r_pi)
            4'd0: begin
                w_b = 34'(r_x);
            end
            4'd1: begin
                w_b = 34'(r_z); w_sub = 1'b1; w_last = 1'b0; w_dest = D_AA;
            end
            4'd2: begin
                w_a = 34'(signed'({1'b0, r_apn})); w_b = 34'(signed'({1'b0, r_dt}));
                w_first = 1'b0; w_dest = D_AA;
            end
            4'd3: begin
                w_b = 34'(r_bb); w_sub = 1'b1; w_dest = D_AB;
            end
            4'd4: begin
                w_b = 34'(r_bb); w_sub = 1'b1; w_dest = D_BA;
            end
            4'd5: begin
                w_a = 34'(signed'({1'b0, r_bpn})); w_b = 34'(signed'({1'b0, r_dt}));
                w_dest = D_BB;
            end
            4'd6: begin
                w_a = 34'(r_k0); w_b = 34'(r_x);
            end
            4'd7: begin
                w_a = 34'(r_k1); w_b = 34'(r_x); w_dest = D_BIAS;
            end
            4'd8: begin
                w_a = 34'(r_k1); w_b = 34'(r_aa); w_sub = 1'b1; w_dest = D_BA;
            end
            4'd9: begin
                w_a = 34'(r_k1); w_b = 34'(r_ab); w_sub = 1'b1; w_dest = D_BB;
            end
            4'd10: begin
                w_a = 34'(r_k0); w_b = 34'(r_aa); w_sub = 1'b1; w_dest = D_AA;
            end
            4'd11: begin
                w_a = 34'(r_k0); w_b = 34'(r_ab); w_sub = 1'b1; w_dest = D_AB;
            end
            default: begin
                w_a = '0; w_b = '0;
            end
        endcase
    end

    // Round the product and accumulate onto the base value
    logic [41:0]        w_round;
    logic signed [44:0] w_term, w_base, w_sum;
    logic signed [31:0] w_sat;
    logic [65:0]        w_rsum;
    always_comb begin
        w_rsum  = r_prod + 66'd8388608;
        w_round = w_rsum[65:24];
        w_term  = r_neg ? -signed'({3'b000, w_round}) : signed'({3'b000, w_round});
        case (w_dest)
            D_ANG:   w_base = 45'(r_angle);
            D_BIAS:  w_base = 45'(r_bias);
            D_AA:    w_base = 45'(r_aa);
            D_AB:    w_base = 45'(r_ab);
            D_BA:    w_base = 45'(r_ba);
            D_BB:    w_base = 45'(r_bb);
            default: w_base = '0;
        endcase
        w_sum = (w_first ? w_base : r_acc) + w_term;
        w_sat = gakf_pkg::sat32(w_sum);
    end

    // Innovation variance for an update
    logic signed [33:0] w_s;
    assign w_s = 34'(r_aa) + 34'(signed'({1'b0, r_mn}));

    // One restoring division step
    logic [33:0] w_rsh;
    logic        w_ge;
    assign w_rsh = {r_rem, r_dvd[55]};
    assign w_ge  = w_rsh >= {1'b0, r_dmag};

    // Saturated gain from the finished quotient
    logic signed [31:0] w_gain;
    always_comb begin
        if (r_ovf || r_q[31]) w_gain = r_dneg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else                  w_gain = r_dneg ? -signed'(r_q) : signed'(r_q);
    end

    logic [32:0] w_mag_aa, w_mag_ba;
    assign w_mag_aa = gakf_pkg::mag34(34'(r_aa));
    assign w_mag_ba = gakf_pkg::mag34(34'(r_ba));

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_angle     <= gakf_pkg::ANGLE_RESET;
            r_bias      <= '0;
            r_aa        <= '0;
            r_ab        <= '0;
            r_ba        <= '0;
            r_bb        <= '0;
            r_apn       <= gakf_pkg::ANGLE_NOISE_RESET;
            r_bpn       <= gakf_pkg::BIAS_NOISE_RESET;
            r_mn        <= gakf_pkg::MEAS_NOISE_RESET;
            r_out_valid <= 1'b0;
            r_pi        <= '0;
            r_cnt       <= '0;
            r_dsel      <= 1'b0;
            r_fault     <= 1'b0;
        end else begin
            // take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gakf_pkg::REG_ANGLE_NOISE: r_apn <= i_cfg_data;
                    gakf_pkg::REG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                    gakf_pkg::REG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop the output word once taken, unless a new one loads now
            if (r_out_valid && !i_out_stall && r_state != S_OUT) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dt    <= i_in_word.time_step;
                        r_fault <= 1'b0;
                        r_pi    <= '0;
                        if (i_in_word.opcode == gakf_pkg::OP_PREDICT) begin
                            r_x     <= 33'(i_in_word.gyro_rate) - 33'(r_bias);
                            r_z     <= 33'(r_ba) + 33'(r_ab);
                            r_state <= S_MUL;
                        end else if (w_s == '0) begin
                            r_fault <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_x     <= 33'(i_in_word.measured_angle) - 33'(r_angle);
                            r_dmag  <= gakf_pkg::mag34(w_s);
                            r_sneg  <= w_s[33];
                            r_dneg  <= r_aa[31] ^ w_s[33];
                            r_dvd   <= {w_mag_aa[31:0], 24'b0};
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_ovf   <= 1'b0;
                            r_cnt   <= '0;
                            r_dsel  <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? 33'(w_rsh - {1'b0, r_dmag}) : w_rsh[32:0];
                    r_q   <= {r_q[30:0], w_ge};
                    r_ovf <= r_ovf | r_q[31];
                    r_dvd <= {r_dvd[54:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd55) r_state <= S_DEND;
                end
                S_DEND: begin
                    if (!r_dsel) begin
                        // hold the first gain, start on the second
                        r_k0    <= w_gain;
                        r_dsel  <= 1'b1;
                        r_dneg  <= r_ba[31] ^ r_sneg;
                        r_dvd   <= {w_mag_ba[31:0], 24'b0};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_k1    <= w_gain;
                        r_pi    <= 4'd6;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= {33'b0, gakf_pkg::mag34(w_a)} * {33'b0, gakf_pkg::mag34(w_b)};
                    r_neg   <= w_a[33] ^ w_b[33] ^ w_sub;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= w_sum;
                    if (w_last) begin
                        case (w_dest)
                            D_ANG:   r_angle <= w_sat;
                            D_BIAS:  r_bias  <= w_sat;
                            D_AA:    r_aa    <= w_sat;
                            D_AB:    r_ab    <= w_sat;
                            D_BA:    r_ba    <= w_sat;
                            D_BB:    r_bb    <= w_sat;
                            default: ;
                        endcase
                    end
                    r_pi <= r_pi + 4'd1;
                    if (r_pi == 4'd5 || r_pi == 4'd11) r_state <= S_OUT;
                    else                               r_state <= S_MUL;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_word.angle_estimate <= r_angle;
                        r_out_word.bias_estimate  <= r_bias;
                        r_out_word.divide_fault   <= r_fault;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    `GAKF_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE)
    `GAKF_ASSERT_SAME(a_div_nonzero, r_state == S_DIV, r_dmag != '0)
    `GAKF_ASSERT_SAME(a_pi_range, r_state == S_MUL || r_state == S_ACC, r_pi <= 4'd11)
    `GAKF_ASSERT_NEXT(a_out_load, r_state == S_OUT && !(r_out_valid && i_out_stall),
                      r_out_valid && r_state == S_IDLE)

endmodule

FILE: bench/gyro_angle_kalman_filter_tb.sv
`timescale 1ns / 100ps

module gyro_angle_kalman_filter_tb;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    gakf_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    gakf_pkg::t_out_word o_out_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [30:0]         i_cfg_data;

    gyro_angle_kalman_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Filter state mirrored by the bench
    longint    kf_angle, kf_bias, kf_paa, kf_pab, kf_pba, kf_pbb;
    longint    kf_q_angle, kf_q_bias, kf_r_meas;
    gakf_pkg::t_out_word estimates_due[$];
    int        n_errors;
    int        n_words_in;
    int        n_words_out;
    int        n_faults;
    bit        long_hold_req;
    bit        stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("timeout at %0t", $time);
        $display("FAIL gyro_angle_kalman_filter");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Q8.24 product, rounded half away from zero
    function automatic longint qmul(input longint a, input longint b);
        bit         neg;
        logic [63:0] p;
        longint     r;
        neg = (a < 0) != (b < 0);
        p = 64'(abs64(a)) * 64'(abs64(b));
        r = longint'((p + 64'h80_0000) >> 24);
        return neg ? -r : r;
    endfunction

    // Q8.24 quotient, truncated and clamped
    function automatic longint qdiv(input longint n, input longint d);
        bit          neg;
        logic [63:0] q;
        longint      r;
        neg = (n < 0) != (d < 0);
        q = (64'(abs64(n)) << 24) / 64'(abs64(d));
        if (q > 64'd2147483647) q = 64'd2147483648;
        r = longint'(q);
        return clamp32(neg ? -r : r);
    endfunction

    function automatic void kf_reset();
        kf_q_angle = gakf_pkg::ANGLE_NOISE_RESET;
        kf_q_bias  = gakf_pkg::BIAS_NOISE_RESET;
        kf_r_meas  = gakf_pkg::MEAS_NOISE_RESET;
        kf_angle = gakf_pkg::ANGLE_RESET;
        kf_bias = 0;
        kf_paa = 0; kf_pab = 0; kf_pba = 0; kf_pbb = 0;
    endfunction

    // Advance the mirrored filter by one input word
    function automatic gakf_pkg::t_out_word kf_step(input gakf_pkg::t_in_word w);
        gakf_pkg::t_out_word o;
        longint    dt, s, y, k0, k1, oaa, oab, naa, nab, nba, nbb;
        o.divide_fault = 1'b0;
        if (w.opcode == gakf_pkg::OP_PREDICT) begin
            dt = longint'(w.time_step);
            kf_angle = clamp32(kf_angle + qmul(dt, longint'(w.gyro_rate) - kf_bias));
            naa = kf_paa - qmul(dt, kf_pba + kf_pab) + qmul(kf_q_angle, dt);
            nab = kf_pab - qmul(dt, kf_pbb);
            nba = kf_pba - qmul(dt, kf_pbb);
            nbb = kf_pbb + qmul(kf_q_bias, dt);
            kf_paa = clamp32(naa); kf_pab = clamp32(nab);
            kf_pba = clamp32(nba); kf_pbb = clamp32(nbb);
        end else begin
            s = kf_paa + kf_r_meas;
            if (s == 0) begin
                o.divide_fault = 1'b1;
            end else begin
                y = longint'(w.measured_angle) - kf_angle;
                k0 = qdiv(kf_paa, s);
                k1 = qdiv(kf_pba, s);
                oaa = kf_paa; oab = kf_pab;
                kf_angle = clamp32(kf_angle + qmul(k0, y));
                kf_bias = clamp32(kf_bias + qmul(k1, y));
                kf_paa = clamp32(oaa - qmul(k0, oaa));
                kf_pab = clamp32(oab - qmul(k0, oab));
                kf_pba = clamp32(kf_pba - qmul(k1, oaa));
                kf_pbb = clamp32(kf_pbb - qmul(k1, oab));
            end
        end
        o.angle_estimate = kf_angle[31:0];
        o.bias_estimate = kf_bias[31:0];
        return o;
    endfunction

    // Send one word after a random gap, hold it until accepted
    task automatic send_word(input gakf_pkg::t_in_word w, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_in_word <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        estimates_due.push_back(kf_step(w));
        n_words_in++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        if (w.opcode == gakf_pkg::OP_UPDATE && o_in_stall === 1'bx) begin
            $display("%0t o_in_stall: expected 0 or 1 got %b", $time, o_in_stall);
            n_errors++;
        end
        @(negedge i_clk);
    endtask

    function automatic gakf_pkg::t_in_word predict_word(input logic signed [31:0] rate,
                                                        input logic [24:0] dt);
        gakf_pkg::t_in_word w;
        w.opcode = gakf_pkg::OP_PREDICT;
        w.gyro_rate = rate;
        w.time_step = dt;
        w.measured_angle = $urandom;
        return w;
    endfunction

    function automatic gakf_pkg::t_in_word update_word(input logic signed [31:0] meas);
        gakf_pkg::t_in_word w;
        w.opcode = gakf_pkg::OP_UPDATE;
        w.gyro_rate = $urandom;
        w.time_step = 25'($urandom);
        w.measured_angle = meas;
        return w;
    endfunction

    // Wait for every estimate, then let the block settle
    task automatic drain();
        int guard;
        guard = 0;
        while (estimates_due.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (160) @(negedge i_clk);
    endtask

    task automatic write_noise(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gakf_pkg::REG_ANGLE_NOISE: kf_q_angle = val;
            gakf_pkg::REG_BIAS_NOISE:  kf_q_bias = val;
            gakf_pkg::REG_MEAS_NOISE:  kf_r_meas = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Receiver: random wait per word, long hold on request
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (stall_enable) begin
                hold = $urandom_range(0, 7);
                if (hold != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                end
                i_out_stall <= 1'b0;
                // release until one word is taken
                do @(posedge i_clk); while (!o_out_valid && !long_hold_req);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted estimate with the oldest one due
    always @(posedge i_clk) begin
        gakf_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_words_out++;
            if (estimates_due.size() == 0) begin
                $display("%0t unexpected word: got %h", $time, o_out_word);
                n_errors++;
            end else begin
                want = estimates_due.pop_front();
                if (want.divide_fault) n_faults++;
                if (o_out_word.angle_estimate !== want.angle_estimate) begin
                    $display("%0t angle_estimate: expected %h got %h", $time,
                             want.angle_estimate, o_out_word.angle_estimate);
                    n_errors++;
                end
                if (o_out_word.bias_estimate !== want.bias_estimate) begin
                    $display("%0t bias_estimate: expected %h got %h", $time,
                             want.bias_estimate, o_out_word.bias_estimate);
                    n_errors++;
                end
                if (o_out_word.divide_fault !== want.divide_fault) begin
                    $display("%0t divide_fault: expected %b got %b", $time,
                             want.divide_fault, o_out_word.divide_fault);
                    n_errors++;
                end
            end
        end
    end

    // Field extremes, both opcodes, zero S, negative S
    task automatic test_directed();
        send_word(update_word(32'sh7FFFFFFF));
        send_word(predict_word(32'sh7FFFFFFF, 25'h1000000));
        send_word(predict_word(32'sh80000000, 25'h1000000));
        send_word(predict_word(32'sh7FFFFFFF, 25'h1FFFFFF));
        send_word(predict_word(32'sh80000000, 25'h1FFFFFF));
        send_word(predict_word(32'sh0, 25'h0));
        send_word(update_word(32'sh80000000));
        send_word(update_word(32'sh7FFFFFFF));
        send_word(predict_word(32'sh00010000, 25'h0010000));
        send_word(update_word(32'sh0));
        send_word(predict_word(32'shFFFF0000, 25'h0800000));
        send_word(update_word(32'sh005A0000));
        drain();
        // Zero S: no measurement noise, first update clears cov_aa, second faults
        write_noise(gakf_pkg::REG_MEAS_NOISE, 31'd0);
        write_noise(gakf_pkg::REG_ANGLE_NOISE, 31'd0);
        write_noise(gakf_pkg::REG_BIAS_NOISE, 31'd0);
        send_word(predict_word(32'sh1234_5678, 25'h0));
        send_word(update_word(32'sh0));
        send_word(update_word(32'sh0));
        // Rounding halves: rate 1 lsb times half-step
        send_word(predict_word(32'sh1, 25'h0800000));
        send_word(predict_word(-32'sh1, 25'h0800000));
        drain();
        // Negative S: large negative covariance against small noise
        write_noise(gakf_pkg::REG_BIAS_NOISE, 31'h7FFFFFFF);
        write_noise(gakf_pkg::REG_ANGLE_NOISE, 31'd1);
        send_word(predict_word(32'sh0001_0000, 25'h1000000));
        send_word(predict_word(32'sh0001_0000, 25'h1000000));
        send_word(predict_word(32'sh0001_0000, 25'h1000000));
        send_word(update_word(32'sh0010_0000));
        send_word(update_word(-32'sh0010_0000));
        drain();
    endtask

    // Sensor loop: small-dt predicts and updates in equal share, plus some fully random words
    task automatic test_random(input int n_items);
        gakf_pkg::t_in_word w;
        int       i;
        for (i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 9))
                0: w = predict_word($urandom, 25'($urandom));
                1: w = update_word($urandom);
                2, 3, 4, 5: w = predict_word($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                                             25'($urandom_range(0, 25'h0080000)));
                default: w = update_word($urandom_range(0, 32'h00FF_FFFF)
                                         + 32'h0050_0000);
            endcase
            send_word(w);
        end
    endtask

    // Block the receiver while the sender keeps offering words
    task automatic test_backpressure();
        int i;
        long_hold_req = 1'b1;
        for (i = 0; i < 6; i++) begin
            send_word(predict_word($urandom, 25'($urandom_range(0, 4096))), 1);
        end
        drain();
        // Sender pauses for each result in turn
        for (i = 0; i < 6; i++) begin
            send_word(update_word($urandom));
            drain();
        end
    endtask

    task automatic test_config_sweep();
        logic [30:0] vals[4];
        int k;
        vals = '{31'd0, 31'h7FFFFFFF, 31'd503316, 31'h0100_0000};
        for (k = 0; k < 4; k++) begin
            write_noise(gakf_pkg::REG_ANGLE_NOISE, vals[k]);
            write_noise(gakf_pkg::REG_BIAS_NOISE, vals[(k + 1) % 4]);
            write_noise(gakf_pkg::REG_MEAS_NOISE, vals[(k + 2) % 4]);
            test_random(100);
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = gakf_pkg::REG_ANGLE_NOISE;
        i_cfg_data = '0;
        n_errors = 0;
        n_words_in = 0;
        n_words_out = 0;
        n_faults = 0;
        long_hold_req = 1'b0;
        stall_enable = 1'b0;
        kf_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        stall_enable = 1'b1;
        test_random(150);
        drain();
        test_backpressure();
        test_config_sweep();
        stall_enable = 1'b0;
        test_random(30);
        drain();

        $display("covered %0d words in, %0d out, %0d zero-S faults", n_words_in,
                 n_words_out, n_faults);
        $display("noise registers swept through zero and full scale, with stalls");
        if (n_errors == 0 && estimates_due.size() == 0) begin
            $display("PASS gyro_angle_kalman_filter");
        end else begin
            $display("FAIL gyro_angle_kalman_filter");
        end
        $finish;
    end
endmodule
